// ===== hw/rtl/spal_pkg.sv =====
// shared types and constants for the slot pool with dense active list
// no dependencies; imported by the top level and the testbench
package spal_pkg;

  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_ACTIVE = 2'd2,
    ST_RANGE      = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [SLOT_W-1:0] slot_in;
    logic [SLOT_W-1:0] position_in;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot_out;
    logic [COUNT_W-1:0] active_count;
  } out_item_t;

endpackage

// ===== hw/rtl/spal_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module spal_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/slot_pool_with_dense_active_list_unit.sv =====
// top level of the slot pool: command sequencer around three rams
// depends on spal_pkg and spal_ram
// a handle allocator over SLOTS slots with a free stack, a dense list of active slots and a
// per-slot position table, each in its own ram with a registered read. one item is
// worked on at a time: alloc, read and clear go through accept, then execute; free goes
// through accept and position lookup, fetch of the list entry at that position for the active
// check, fetch of the last list entry, then the move into the hole, and stops after the active
// check when the slot is not active; the free figure is set by the single read port of the
// active list, which must be read twice in series behind the position lookup. results sit in
// an output register, so the next item is taken while a result waits; every step after the
// accept waits while the output register is full and not being drained. no clearing pass
// is needed after reset or clear: a high-water mark records how deep the free stack has been
// popped since the last refill, and an entry below it that was never written reads as its own
// index. free of an inactive slot, alloc on an empty pool and a read past the list end are
// reported in the status field and change nothing.
module slot_pool_with_dense_active_list_unit #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spal_pkg::in_item_t   in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spal_pkg::out_item_t  out_o
);

  import spal_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);      // slot index width
  localparam int unsigned CW = $clog2(SLOTS + 1);  // count width, holds SLOTS itself

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FREE_CHK,
    S_FREE_MOVE
  } state_e;

  state_e              state_q;
  cmd_e                cmd_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   posn_q;
  logic [CW-1:0]       used_q;
  logic [CW-1:0]       hwm_q;      // deepest free stack pop since last refill
  logic                out_valid_q;
  out_item_t           out_q;

  // ram ports
  logic          fs_we, fs_re, sp_we, sp_re, al_we, al_re;
  logic [IW-1:0] fs_waddr, fs_raddr, sp_waddr, sp_raddr, al_waddr, al_raddr;
  logic [IW-1:0] fs_wdata, sp_wdata, al_wdata;
  logic [IW-1:0] fs_rdata, sp_rdata, al_rdata;

  logic          accept;
  logic          out_free;
  logic          step;
  logic          done;
  logic          full;
  logic          id_fresh;
  logic [CW-1:0] top_idx;
  logic [IW-1:0] alloc_id;
  logic [IW-1:0] slot_iw;
  logic          slot_ok;
  logic          posn_ok;
  logic          is_active;

  function automatic out_item_t make_out(status_e st, logic [IW-1:0] slot,
                                         logic [CW-1:0] cnt);
    out_item_t o;
    o.status       = st;
    o.slot_out     = SLOT_W'(slot);
    o.active_count = COUNT_W'(cnt);
    return o;
  endfunction

  // handshake
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign step        = (state_q != S_IDLE) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // step that loads a result item into the output register
  assign done = step && ((state_q == S_EXEC && cmd_q != CMD_FREE) ||
                         (state_q == S_FREE_CHK && !is_active) ||
                         (state_q == S_FREE_MOVE));

  // alloc: top of the free stack, or its own index if never pushed since refill
  assign full     = (used_q == CW'(SLOTS));
  assign id_fresh = (used_q == hwm_q);
  assign top_idx  = CW'(SLOTS - 1) - used_q;
  assign alloc_id = id_fresh ? IW'(top_idx) : fs_rdata;

  // free: slot is active when its position is in use and the list points back at it
  assign slot_iw   = IW'(slot_q);
  assign slot_ok   = (32'(slot_q) < SLOTS);
  assign is_active = slot_ok && (CW'(sp_rdata) < used_q) && (al_rdata == slot_iw);

  // read: position must lie inside the used part of the list
  assign posn_ok = (32'(posn_q) < 32'(used_q));

  // ram control
  always_comb begin
    fs_re    = 1'b0;
    fs_raddr = IW'(top_idx);
    fs_we    = 1'b0;
    fs_waddr = IW'(CW'(SLOTS) - used_q);
    fs_wdata = slot_iw;
    sp_re    = 1'b0;
    sp_raddr = IW'(in_i.slot_in);
    sp_we    = 1'b0;
    sp_waddr = alloc_id;
    sp_wdata = IW'(used_q);
    al_re    = 1'b0;
    al_raddr = IW'(in_i.position_in);
    al_we    = 1'b0;
    al_waddr = IW'(used_q);
    al_wdata = alloc_id;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_i.cmd)
            CMD_ALLOC: fs_re = 1'b1;
            CMD_FREE:  sp_re = 1'b1;
            CMD_READ:  al_re = 1'b1;
            CMD_CLEAR: ;
          endcase
        end
      end
      S_EXEC: begin
        if (step) begin
          unique case (cmd_q)
            CMD_ALLOC: begin
              if (!full) begin
                al_we = 1'b1;
                sp_we = 1'b1;
              end
            end
            CMD_FREE: begin
              // list entry at the slot's recorded position
              al_re    = 1'b1;
              al_raddr = sp_rdata;
            end
            CMD_READ, CMD_CLEAR: ;
          endcase
        end
      end
      S_FREE_CHK: begin
        if (step && is_active) begin
          fs_we    = 1'b1;
          al_re    = 1'b1;
          al_raddr = IW'(used_q - CW'(1));
        end
      end
      S_FREE_MOVE: begin
        // last entry moves into the hole
        if (step) begin
          al_we    = 1'b1;
          al_waddr = sp_rdata;
          al_wdata = al_rdata;
          sp_we    = 1'b1;
          sp_waddr = al_rdata;
          sp_wdata = sp_rdata;
        end
      end
    endcase
  end

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_ALLOC;
      slot_q      <= '0;
      posn_q      <= '0;
      used_q      <= '0;
      hwm_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= in_i.cmd;
            slot_q  <= in_i.slot_in;
            posn_q  <= in_i.position_in;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (step) begin
            unique case (cmd_q)
              CMD_ALLOC: begin
                if (full) begin
                  out_q <= make_out(ST_EMPTY, '0, used_q);
                end else begin
                  out_q  <= make_out(ST_OK, alloc_id, used_q + CW'(1));
                  used_q <= used_q + CW'(1);
                  if (id_fresh) begin
                    hwm_q <= hwm_q + CW'(1);
                  end
                end
                state_q <= S_IDLE;
              end
              CMD_FREE: begin
                state_q <= S_FREE_CHK;
              end
              CMD_READ: begin
                if (posn_ok) begin
                  out_q <= make_out(ST_OK, al_rdata, used_q);
                end else begin
                  out_q <= make_out(ST_RANGE, '0, used_q);
                end
                state_q <= S_IDLE;
              end
              CMD_CLEAR: begin
                used_q  <= '0;
                hwm_q   <= '0;
                out_q   <= make_out(ST_OK, '0, '0);
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_FREE_CHK: begin
          if (step) begin
            if (is_active) begin
              state_q <= S_FREE_MOVE;
            end else begin
              out_q   <= make_out(ST_NOT_ACTIVE, '0, used_q);
              state_q <= S_IDLE;
            end
          end
        end
        S_FREE_MOVE: begin
          if (step) begin
            used_q  <= used_q - CW'(1);
            out_q   <= make_out(ST_OK, slot_iw, used_q - CW'(1));
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  // free stack
  spal_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_free_stack (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .re_i    (fs_re),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  // dense active list
  spal_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_active_list (
    .clk_i   (clk_i),
    .we_i    (al_we),
    .waddr_i (al_waddr),
    .wdata_i (al_wdata),
    .re_i    (al_re),
    .raddr_i (al_raddr),
    .rdata_o (al_rdata)
  );

  // position of each slot in the active list
  spal_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_slot_position (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (sp_waddr),
    .wdata_i (sp_wdata),
    .re_i    (sp_re),
    .raddr_i (sp_raddr),
    .rdata_o (sp_rdata)
  );

  // checks
  a_used_below_hwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= hwm_q)
    else $error("active count above free stack high-water mark");

  a_hwm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q <= CW'(SLOTS))
    else $error("high-water mark beyond pool size");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cmd_q == CMD_ALLOC && out_free && !full)
      |=> (used_q == $past(used_q) + CW'(1)))
    else $error("alloc did not bump the active count");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cmd_q == CMD_CLEAR && out_free)
      |=> (used_q == '0 && hwm_q == '0 && out_valid_q))
    else $error("clear left pool state behind");

  a_free_only_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE_MOVE) |-> (used_q != '0))
    else $error("free move with an empty active list");

endmodule

// ===== verif/tb.sv =====
// testbench for slot_pool_with_dense_active_list_unit: directed, fill-to-empty and random items
// depends on spal_pkg and the rtl of the unit; a local predictor checks every result item
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spal_pkg::*;

  localparam int unsigned NSLOTS   = 1024;
  localparam int unsigned N_RANDOM = 300;
  localparam int unsigned MAX_CYC  = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_o;

  slot_pool_with_dense_active_list_unit #(
    .SLOTS(NSLOTS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------
  // shadow of the pool, advanced once per accepted item
  // ------------------------------------------------------------------
  logic [SLOT_W-1:0] free_stk [NSLOTS];
  logic [SLOT_W-1:0] list_slots [NSLOTS];
  logic [SLOT_W-1:0] slot_pos [NSLOTS];
  int unsigned       n_active;

  out_item_t pending_results[$];  // results still owed by the unit, oldest first
  in_item_t  cmd_q[$];            // items waiting for the driver
  int        n_errors = 0;

  function automatic void refill_pool();
    for (int i = 0; i < NSLOTS; i++) free_stk[i] = SLOT_W'(i);
    n_active = 0;
  endfunction

  // works out the result of one command and updates the shadow
  function automatic out_item_t apply_pool_cmd(in_item_t it);
    out_item_t r;
    int unsigned p;
    logic [SLOT_W-1:0] id;
    logic [SLOT_W-1:0] last;
    r.status   = ST_OK;
    r.slot_out = '0;
    case (it.cmd)
      CMD_ALLOC: begin
        if (n_active >= NSLOTS) begin
          r.status = ST_EMPTY;
        end else begin
          id = free_stk[NSLOTS - n_active - 1];
          list_slots[n_active] = id;
          slot_pos[id] = SLOT_W'(n_active);
          n_active++;
          r.slot_out = id;
        end
      end
      CMD_FREE: begin
        p = 32'(slot_pos[it.slot_in]);
        if (p < n_active && list_slots[p] == it.slot_in) begin
          // push back, then move the last list entry into the hole
          free_stk[NSLOTS - n_active] = it.slot_in;
          n_active--;
          last = list_slots[n_active];
          list_slots[p] = last;
          slot_pos[last] = SLOT_W'(p);
          r.slot_out = it.slot_in;
        end else begin
          r.status = ST_NOT_ACTIVE;
        end
      end
      CMD_READ: begin
        if (it.position_in < n_active) r.slot_out = list_slots[it.position_in];
        else r.status = ST_RANGE;
      end
      default: refill_pool();
    endcase
    r.active_count = COUNT_W'(n_active);
    return r;
  endfunction

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      list_slots[i] = '0;
      slot_pos[i]   = '0;
    end
    refill_pool();
  end

  // ------------------------------------------------------------------
  // driver: bursts of items with random gaps, payload held while stalled
  // ------------------------------------------------------------------
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    in_item_t nxt;
    logic     drive;
    if (rst_ni && !(in_valid_i && !in_ready_o)) begin
      drive = 1'b0;
      nxt   = in_i;
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() > 0) begin
        nxt   = cmd_q.pop_front();
        drive = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          // now and then a long stretch with no idling at all
          if ($urandom_range(7) == 0) begin
            burst_left = 64;
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(12, 1);
            gap_left   = $urandom_range(6, 1);
          end
        end
      end
      in_valid_i <= drive;
      in_i       <= nxt;
    end
  end

  // ------------------------------------------------------------------
  // receiver: stall pattern rotates through always ready, ready at random, and bursts of stall cycles
  // ------------------------------------------------------------------
  int rx_cycle   = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin
    int mode;
    rx_cycle++;
    mode = (rx_cycle / 256) % 3;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (mode == 0) begin
      out_ready_i <= 1'b1;
    end else if (mode == 1) begin
      out_ready_i <= 1'($urandom_range(1));
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(5) == 0) begin
      stall_left = $urandom_range(15, 1);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // monitor: predict on input acceptance, compare on output acceptance
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_results.insert(pending_results.size(), apply_pool_cmd(in_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result item: status %0d slot_out %0d active_count %0d",
                 out_o.status, out_o.slot_out, out_o.active_count);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_o.status !== want.status) begin
            $error("status: expected %0d got %0d", want.status, out_o.status);
            n_errors++;
          end
          if (out_o.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d got %0d", want.slot_out, out_o.slot_out);
            n_errors++;
          end
          if (out_o.active_count !== want.active_count) begin
            $error("active_count: expected %0d got %0d", want.active_count,
                   out_o.active_count);
            n_errors++;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // watchdog
  // ------------------------------------------------------------------
  int n_cycles = 0;

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > MAX_CYC) begin
      $display("[slot_pool_with_dense_active_list_unit] ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------
  task automatic queue_cmd(cmd_e c, int unsigned s, int unsigned p);
    in_item_t it;
    it.cmd         = c;
    it.slot_in     = SLOT_W'(s);
    it.position_in = SLOT_W'(p);
    cmd_q.insert(cmd_q.size(), it);
  endtask

  // sender holds off until every item is out and every result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || pending_results.size() != 0);
  endtask

  initial begin
    int unsigned alloc_bias;
    int unsigned r;
    int unsigned s;
    int unsigned p;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: only entries that have been written are ever looked up
    queue_cmd(CMD_ALLOC, 1023, 1023);
    queue_cmd(CMD_ALLOC, 1023, 1023);
    queue_cmd(CMD_ALLOC, 1023, 1023);
    queue_cmd(CMD_ALLOC, 1023, 1023);
    queue_cmd(CMD_READ, 1023, 0);
    queue_cmd(CMD_READ, 1023, 3);
    queue_cmd(CMD_FREE, 1021, 1023);   // hole in the middle, last entry moves in
    queue_cmd(CMD_FREE, 1020, 1023);   // freeing the last entry itself
    queue_cmd(CMD_FREE, 1021, 1023);   // double free
    queue_cmd(CMD_READ, 1023, 2);      // just past the list end
    queue_cmd(CMD_READ, 1023, 3);
    queue_cmd(CMD_CLEAR, 1023, 1023);
    queue_cmd(CMD_READ, 1023, 0);      // empty list
    queue_cmd(CMD_FREE, 1023, 1023);   // stale slot after a clear
    queue_cmd(CMD_ALLOC, 1023, 1023);
    queue_cmd(CMD_FREE, 1023, 1023);
    queue_cmd(CMD_FREE, 1022, 1023);
    wait_drained();

    // fill the pool to the brim and beyond, then touch both ends
    for (int i = 0; i < NSLOTS + 2; i++) queue_cmd(CMD_ALLOC, 1023, 1023);
    queue_cmd(CMD_READ, 0, 1023);
    queue_cmd(CMD_READ, 0, 0);
    queue_cmd(CMD_FREE, 0, 0);
    queue_cmd(CMD_FREE, 1023, 0);
    queue_cmd(CMD_READ, 0, 1023);
    queue_cmd(CMD_ALLOC, 0, 0);
    queue_cmd(CMD_CLEAR, 0, 0);

    // random: every entry has been written by now, so any field value is fair
    alloc_bias = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      while (cmd_q.size() > 1) @(negedge clk_i);
      if (n == N_RANDOM / 2) wait_drained();
      if (n % 50 == 0) alloc_bias = $urandom_range(80, 15);
      r = $urandom_range(99);
      s = $urandom_range(1023);
      p = $urandom_range(1023);
      if (r < 2) begin
        queue_cmd(CMD_CLEAR, s, p);
      end else if (r < 2 + alloc_bias) begin
        queue_cmd(CMD_ALLOC, s, p);
      end else if ($urandom_range(9) < 6) begin
        // mostly slots that are live right now, some stale or random
        if (n_active > 0 && $urandom_range(99) < 85)
          s = 32'(list_slots[$urandom_range(n_active - 1)]);
        queue_cmd(CMD_FREE, s, p);
      end else begin
        if (n_active > 0 && $urandom_range(99) < 80) p = $urandom_range(n_active - 1);
        queue_cmd(CMD_READ, s, p);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("[slot_pool_with_dense_active_list_unit] OK");
    end else begin
      $display("[slot_pool_with_dense_active_list_unit] ERROR");
    end
    $finish;
  end

endmodule
